// ----- rtl/core/gfau_pkg.sv -----
// Package for the GF(2^8) arithmetic unit: opcodes, field constants and
// the step counts of the inversion sequence. No dependencies.
`default_nettype none

package gfau_pkg;

    // Field element
    typedef logic [7:0] gf_byte_t;

    // Operation codes carried in the input item's tuser
    typedef logic [2:0] gf_op_t;

    localparam gf_op_t OP_XOR = 3'd0;
    localparam gf_op_t OP_MUL = 3'd1;
    localparam gf_op_t OP_INV = 3'd2;
    localparam gf_op_t OP_DIV = 3'd3;
    localparam gf_op_t OP_ROT = 3'd4;

    // Reduction term of x^8 + x^4 + x^3 + x + 1 once x^8 is dropped
    localparam gf_byte_t GF_REDUCE = 8'h1b;
    localparam gf_byte_t GF_MSB    = 8'h80;

    // Inversion as v^254: alternating square / multiply-by-v steps 0..11,
    // a final square at step 12, and for divide one multiply by a at step 13
    typedef logic [3:0] gf_step_t;

    localparam gf_step_t STEP_LAST_INV = 4'd12;
    localparam gf_step_t STEP_LAST_DIV = 4'd13;

endpackage

`default_nettype wire

// ----- rtl/core/gf256_arithmetic_unit.sv -----
// Top level of the GF(2^8) arithmetic unit: stream handshake, sequencer
// and output register around the shared multiplier. Depends on gfau_pkg
// and gfau_mul.
//
// One item in, one result out. The unit holds one item at a time and drops
// s_tready from acceptance until the result has moved into the output
// register. Inverse and divide use the single shared multiplier, which forms
// v^254 in 13 square / multiply steps and, for divide, one more multiply by
// a. A result waiting in the output register does not block acceptance of the
// next item; a second finished result waits inside the unit, with s_tready
// low, until the output register frees. Divide by zero gives result 0 with
// the flag set; inverse of zero gives 0.
`default_nettype none

module gf256_arithmetic_unit import gfau_pkg::*; (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [15:0] s_tdata,   // [7:0] operand_a, [15:8] operand_b
    input  wire [2:0]  s_tuser,   // [2:0] opcode
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [7:0] result_byte
    output logic [0:0] m_tuser    // [0] divide_by_zero
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0] state_reg, state_next;
    gf_op_t     op_reg, op_next;
    gf_byte_t   a_reg, a_next;
    gf_byte_t   base_reg, base_next;
    gf_byte_t   acc_reg, acc_next;
    logic       dz_reg, dz_next;
    gf_step_t   step_reg, step_next;
    logic       mvalid_reg, mvalid_next;
    gf_byte_t   mdata_reg, mdata_next;
    logic       mdz_reg, mdz_next;

    gf_byte_t   mul_x, mul_y, mul_p;
    gf_byte_t   rot_val;
    logic [15:0] rot_dbl;
    logic       s_fire;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = mdz_reg;

    // Rotate left by the low three bits of b
    assign rot_dbl = {a_reg, a_reg} << base_reg[2:0];
    assign rot_val = rot_dbl[15:8];

    // Pick multiplier operands: a times b for multiply; otherwise square on even
    // steps, times base on odd steps, times a on the closing divide step
    always_comb begin
        mul_x = acc_reg;
        mul_y = acc_reg;
        if (op_reg == OP_MUL) begin
            mul_x = a_reg;
            mul_y = base_reg;
        end else if (step_reg == STEP_LAST_DIV) begin
            mul_y = a_reg;
        end else if (step_reg[0]) begin
            mul_y = base_reg;
        end
    end

    gfau_mul u_mul (
        .mul_x (mul_x),
        .mul_y (mul_y),
        .mul_p (mul_p)
    );

    // Sequencer and datapath
    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        a_next      = a_reg;
        base_next   = base_reg;
        acc_next    = acc_reg;
        dz_next     = dz_reg;
        step_next   = step_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        mdz_next    = mdz_reg;

        // Retire the shown result
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    op_next   = s_tuser;
                    a_next    = s_tdata[7:0];
                    step_next = '0;
                    dz_next   = (s_tuser == OP_DIV) && (s_tdata[15:8] == 8'h00);
                    if (s_tuser == OP_INV) begin
                        base_next = s_tdata[7:0];
                        acc_next  = s_tdata[7:0];
                    end else begin
                        base_next = s_tdata[15:8];
                        acc_next  = s_tdata[15:8];
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                step_next = step_reg + 4'd1;
                unique case (op_reg)
                    OP_XOR: begin
                        acc_next   = a_reg ^ base_reg;
                        state_next = ST_HOLD;
                    end
                    OP_MUL: begin
                        acc_next   = mul_p;
                        state_next = ST_HOLD;
                    end
                    OP_INV: begin
                        acc_next = mul_p;
                        if (step_reg == STEP_LAST_INV) begin
                            state_next = ST_HOLD;
                        end
                    end
                    OP_DIV: begin
                        acc_next = mul_p;
                        if (step_reg == STEP_LAST_DIV) begin
                            state_next = ST_HOLD;
                        end
                    end
                    OP_ROT: begin
                        acc_next   = rot_val;
                        state_next = ST_HOLD;
                    end
                    default: begin
                        acc_next   = 8'h00;
                        state_next = ST_HOLD;
                    end
                endcase
            end
            ST_HOLD: begin
                // Move the result into the output register once it is free
                if (out_free) begin
                    mvalid_next = 1'b1;
                    mdata_next  = acc_reg;
                    mdz_next    = dz_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        a_reg     <= a_next;
        base_reg  <= base_next;
        acc_reg   <= acc_next;
        dz_reg    <= dz_next;
        step_reg  <= step_next;
        mdata_reg <= mdata_next;
        mdz_reg   <= mdz_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/gfau_mul.sv -----
// Shared GF(2^8) multiplier of the arithmetic unit: one product per cycle,
// shift-and-add reduced by the AES polynomial. Depends on gfau_pkg.
`default_nettype none

module gfau_mul import gfau_pkg::*; (
    input  wire gf_byte_t mul_x,
    input  wire gf_byte_t mul_y,
    output gf_byte_t      mul_p
);

    // Shift-and-add over the eight bits of mul_y
    always_comb begin
        gf_byte_t acc;
        gf_byte_t shf;
        acc = '0;
        shf = mul_x;
        for (int k = 0; k < 8; k++) begin
            if (mul_y[k]) begin
                acc = acc ^ shf;
            end
            if ((shf & GF_MSB) != 8'h00) begin
                shf = {shf[6:0], 1'b0} ^ GF_REDUCE;
            end else begin
                shf = {shf[6:0], 1'b0};
            end
        end
        mul_p = acc;
    end

endmodule

`default_nettype wire
